// ===== sv/mts_pkg.sv =====
// Package for the melody tone sequencer: command codes, note counts and the
// note ROM (frequency, duration and due threshold per note).
// No dependencies.
`default_nettype none

package mts_pkg;

  // Command codes carried on the action field
  localparam logic [1:0] ACT_TICK   = 2'd0;
  localparam logic [1:0] ACT_ALARM  = 2'd1;
  localparam logic [1:0] ACT_JINGLE = 2'd2;
  localparam logic [1:0] ACT_STOP   = 2'd3;

  // Melody select codes
  localparam logic SEL_ALARM  = 1'b0;
  localparam logic SEL_JINGLE = 1'b1;

  // Note counts per melody (1 to 32)
  localparam int unsigned ALARM_NOTES  = 25;
  localparam int unsigned JINGLE_NOTES = 4;

  localparam int unsigned IDX_W  = 5;
  localparam int unsigned FREQ_W = 11;
  localparam int unsigned LEN_W  = 9;
  localparam int unsigned MS_W   = 32;

  localparam logic [IDX_W:0] ALARM_COUNT  = (IDX_W+1)'(ALARM_NOTES);
  localparam logic [IDX_W:0] JINGLE_COUNT = (IDX_W+1)'(JINGLE_NOTES);

  // Note durations at 175 beats per minute
  localparam int unsigned BPM_TEMPO = 175;
  localparam logic [LEN_W-1:0] LEN_Q  = LEN_W'(60000 / BPM_TEMPO);
  localparam logic [LEN_W-1:0] LEN_HD = LEN_W'(45000 / BPM_TEMPO);
  localparam logic [LEN_W-1:0] LEN_H  = LEN_W'(30000 / BPM_TEMPO);
  localparam logic [LEN_W-1:0] LEN_S  = LEN_W'(15000 / BPM_TEMPO);

  // Due threshold: smallest elapsed time with elapsed * 10 >= len * 11
  localparam logic [LEN_W-1:0] THR_Q  = LEN_W'((LEN_Q * 11 + 9) / 10);
  localparam logic [LEN_W-1:0] THR_HD = LEN_W'((LEN_HD * 11 + 9) / 10);
  localparam logic [LEN_W-1:0] THR_H  = LEN_W'((LEN_H * 11 + 9) / 10);
  localparam logic [LEN_W-1:0] THR_S  = LEN_W'((LEN_S * 11 + 9) / 10);
  localparam logic [LEN_W-1:0] LEN_J  = LEN_W'(90);
  localparam logic [LEN_W-1:0] LEN_JL = LEN_W'(220);
  localparam logic [LEN_W-1:0] THR_J  = LEN_W'((90 * 11 + 9) / 10);
  localparam logic [LEN_W-1:0] THR_JL = LEN_W'((220 * 11 + 9) / 10);

  // Frequencies in hertz
  localparam logic [FREQ_W-1:0] F_DS5 = FREQ_W'(622);
  localparam logic [FREQ_W-1:0] F_B4  = FREQ_W'(494);
  localparam logic [FREQ_W-1:0] F_AS4 = FREQ_W'(466);
  localparam logic [FREQ_W-1:0] F_A4  = FREQ_W'(440);
  localparam logic [FREQ_W-1:0] F_C5  = FREQ_W'(523);
  localparam logic [FREQ_W-1:0] F_E5  = FREQ_W'(659);
  localparam logic [FREQ_W-1:0] F_G5  = FREQ_W'(784);
  localparam logic [FREQ_W-1:0] F_C6  = FREQ_W'(1047);
  localparam logic [FREQ_W-1:0] F_REST = '0;

  typedef struct packed {
    logic [FREQ_W-1:0] freq;
    logic [LEN_W-1:0]  len;
    logic [LEN_W-1:0]  thr;
  } note_t;

  localparam note_t NOTE_EMPTY = '{freq: F_REST, len: '0, thr: '0};

  // Note ROM; entries past the stored notes read as an empty rest
  function automatic note_t note_lookup(input logic sel, input logic [IDX_W-1:0] idx);
    note_t n;
    n = NOTE_EMPTY;
    if (sel == SEL_JINGLE) begin
      unique case (idx)
        5'd0:    n = '{freq: F_C5, len: LEN_J,  thr: THR_J};
        5'd1:    n = '{freq: F_E5, len: LEN_J,  thr: THR_J};
        5'd2:    n = '{freq: F_G5, len: LEN_J,  thr: THR_J};
        5'd3:    n = '{freq: F_C6, len: LEN_JL, thr: THR_JL};
        default: n = NOTE_EMPTY;
      endcase
    end else begin
      unique case (idx) inside
        5'd0:    n = '{freq: F_B4,  len: LEN_S,  thr: THR_S};
        5'd1:    n = '{freq: F_B4,  len: LEN_HD, thr: THR_HD};
        5'd2:    n = '{freq: F_DS5, len: LEN_H,  thr: THR_H};
        5'd3:    n = '{freq: F_A4,  len: LEN_H,  thr: THR_H};
        5'd4, 5'd7, 5'd10, 5'd13, 5'd16, 5'd19, 5'd22:
                 n = '{freq: F_REST, len: LEN_Q, thr: THR_Q};
        5'd5, 5'd8, 5'd11, 5'd14, 5'd17, 5'd20, 5'd23:
                 n = '{freq: F_DS5, len: LEN_H, thr: THR_H};
        5'd6, 5'd9, 5'd12, 5'd15, 5'd18, 5'd21, 5'd24:
                 n = '{freq: F_AS4, len: LEN_H, thr: THR_H};
        default: n = NOTE_EMPTY;
      endcase
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// ===== sv/melody_tone_sequencer.sv =====
// Melody tone sequencer top level: command decode, note timing and result
// register. Depends on mts_pkg for command codes and the note ROM.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one command beat: action
//   (tick, play alarm, play jingle, stop) and now_ms, the millisecond count.
//   Output channel (out_valid/out_ready) returns exactly one result beat per
//   input beat: tone start with frequency and length, silence, and the
//   playing flag after the command.
//   The result beat is registered in the cycle after its input beat. Throughput is
//   one beat per cycle while the receiver takes each result: the note ROM read,
//   the 32-bit elapsed-time subtract and the threshold compare all sit between
//   the state registers and the result register.
//   When the receiver stalls, the result register holds its beat and
//   in_ready drops until that beat is taken, so nothing is lost.
//   Reset (rst, synchronous) clears playback, selects the alarm, zeroes the
//   note index and start time, and empties the result register.
`default_nettype none

module melody_tone_sequencer (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output      logic                        in_ready,
  input  wire logic [1:0]                  action,
  input  wire logic [mts_pkg::MS_W-1:0]    now_ms,
  output      logic                        out_valid,
  input  wire logic                        out_ready,
  output      logic                        tone_start,
  output      logic                        tone_silence,
  output      logic [mts_pkg::FREQ_W-1:0]  tone_frequency_hz,
  output      logic [mts_pkg::LEN_W-1:0]   tone_length_ms,
  output      logic                        is_playing
);

  import mts_pkg::*;

  // Playback state
  logic              playing, playing_next;
  logic              looping, looping_next;
  logic              melody_select, melody_select_next;
  logic [IDX_W-1:0]  note_index, note_index_next;
  logic [MS_W-1:0]   note_start_ms, note_start_ms_next;

  // Result beat
  logic              start_next, silence_next;
  logic [FREQ_W-1:0] freq_next;
  logic [LEN_W-1:0]  len_next;

  logic              in_beat;
  note_t             note;
  logic [MS_W-1:0]   elapsed;
  logic              note_due;
  logic [IDX_W:0]    idx_inc;
  logic [IDX_W:0]    note_count;

  // Accept when the result register is empty or drains this cycle
  assign in_ready = !out_valid || out_ready;
  assign in_beat  = in_valid && in_ready;

  // Look up the current note and check whether it is due
  assign note       = note_lookup(melody_select, note_index);
  assign elapsed    = now_ms - note_start_ms;
  assign note_due   = elapsed >= {{(MS_W-LEN_W){1'b0}}, note.thr};
  assign idx_inc    = {1'b0, note_index} + (IDX_W+1)'(1);
  assign note_count = (melody_select == SEL_JINGLE) ? JINGLE_COUNT : ALARM_COUNT;

  // Decode the command and build the next state and result
  always_comb begin
    playing_next       = playing;
    looping_next       = looping;
    melody_select_next = melody_select;
    note_index_next    = note_index;
    note_start_ms_next = note_start_ms;
    start_next         = 1'b0;
    silence_next       = 1'b0;
    freq_next          = '0;
    len_next           = '0;
    unique case (action) inside
      ACT_ALARM, ACT_JINGLE: begin
        melody_select_next = (action == ACT_JINGLE) ? SEL_JINGLE : SEL_ALARM;
        looping_next       = (action == ACT_ALARM);
        note_index_next    = '0;
        note_start_ms_next = '0;
        playing_next       = 1'b1;
      end
      ACT_STOP: begin
        playing_next    = 1'b0;
        note_index_next = '0;
        silence_next    = 1'b1;
      end
      ACT_TICK: begin
        if (playing && note_due) begin
          note_start_ms_next = now_ms;
          if (note.freq != F_REST) begin
            start_next = 1'b1;
            freq_next  = note.freq;
            len_next   = note.len;
          end else begin
            silence_next = 1'b1;
          end
          if (idx_inc >= note_count) begin
            note_index_next = '0;
            if (!looping) begin
              playing_next = 1'b0;
            end
          end else begin
            note_index_next = idx_inc[IDX_W-1:0];
          end
        end
      end
      default: begin
        playing_next = playing;
      end
    endcase
  end

  // Advance playback state on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      playing       <= 1'b0;
      looping       <= 1'b0;
      melody_select <= SEL_ALARM;
      note_index    <= '0;
      note_start_ms <= '0;
    end else if (in_beat) begin
      playing       <= playing_next;
      looping       <= looping_next;
      melody_select <= melody_select_next;
      note_index    <= note_index_next;
      note_start_ms <= note_start_ms_next;
    end
  end

  // Hold the result beat until the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_beat) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      tone_start        <= start_next;
      tone_silence      <= silence_next;
      tone_frequency_hz <= freq_next;
      tone_length_ms    <= len_next;
      is_playing        <= playing_next;
    end
  end

  // Checks
  a_start_xor_silence: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(tone_start && tone_silence))
    else $error("tone start and silence in the same beat");

  a_tone_has_freq: assert property (@(posedge clk) disable iff (rst)
    (out_valid && tone_start) |-> (tone_frequency_hz != '0 && tone_length_ms != '0))
    else $error("tone start without frequency or length");

  a_no_tone_no_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !tone_start) |-> (tone_frequency_hz == '0 && tone_length_ms == '0))
    else $error("frequency or length without tone start");

  a_stop_halts: assert property (@(posedge clk) disable iff (rst)
    (in_beat && action == ACT_STOP) |=> (!playing && note_index == '0 && tone_silence))
    else $error("stop did not halt playback");

  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("input accepted over a stalled result");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for melody_tone_sequencer: drives command beats over
// valid/ready and checks each result beat against an in-order tone prediction.
// Depends on mts_pkg (command codes, widths, note counts) and the RTL top level.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mts_pkg::*;

  // Score constants, kept apart from the RTL note ROM
  localparam int unsigned TEMPO = 175;
  localparam logic [LEN_W-1:0] NOTE_Q  = LEN_W'(60000 / TEMPO);
  localparam logic [LEN_W-1:0] NOTE_DH = LEN_W'(45000 / TEMPO);
  localparam logic [LEN_W-1:0] NOTE_H  = LEN_W'(30000 / TEMPO);
  localparam logic [LEN_W-1:0] NOTE_S  = LEN_W'(15000 / TEMPO);
  localparam logic [LEN_W-1:0] NOTE_J  = LEN_W'(90);
  localparam logic [LEN_W-1:0] NOTE_JL = LEN_W'(220);
  localparam logic [FREQ_W-1:0] TONE_REST = '0;
  localparam logic [FREQ_W-1:0] TONE_A4   = FREQ_W'(440);
  localparam logic [FREQ_W-1:0] TONE_AS4  = FREQ_W'(466);
  localparam logic [FREQ_W-1:0] TONE_B4   = FREQ_W'(494);
  localparam logic [FREQ_W-1:0] TONE_DS5  = FREQ_W'(622);
  localparam logic [FREQ_W-1:0] TONE_C5   = FREQ_W'(523);
  localparam logic [FREQ_W-1:0] TONE_E5   = FREQ_W'(659);
  localparam logic [FREQ_W-1:0] TONE_G5   = FREQ_W'(784);
  localparam logic [FREQ_W-1:0] TONE_C6   = FREQ_W'(1047);

  localparam int unsigned TOTAL_BEATS = 1650;
  localparam int unsigned CALM_BEATS  = 150;
  localparam int unsigned DRAIN_EVERY = 400;
  localparam int unsigned STALL_LIMIT = 1000;

  typedef struct packed {
    logic              start;
    logic              silence;
    logic [FREQ_W-1:0] freq;
    logic [LEN_W-1:0]  len;
    logic              playing;
  } tone_beat_t;

  // Playback tracker: predicts one tone beat per command and checks results in order
  class tone_checker;
    bit                playing;
    bit                looping;
    bit                sel;
    bit [IDX_W-1:0]    idx;
    bit [MS_W-1:0]     start_ms;
    tone_beat_t        expected_tones[$];
    int unsigned       mismatches;

    function new();
      playing    = 1'b0;
      looping    = 1'b0;
      sel        = SEL_ALARM;
      idx        = '0;
      start_ms   = '0;
      mismatches = 0;
    endfunction

    // Look up one note of the score: frequency (rest is zero) and length
    function void score_note(input bit s, input bit [IDX_W-1:0] i,
                             output bit [FREQ_W-1:0] f, output bit [LEN_W-1:0] d);
      f = TONE_REST;
      d = '0;
      if (s == SEL_JINGLE) begin
        case (i)
          5'd0: begin f = TONE_C5; d = NOTE_J; end
          5'd1: begin f = TONE_E5; d = NOTE_J; end
          5'd2: begin f = TONE_G5; d = NOTE_J; end
          5'd3: begin f = TONE_C6; d = NOTE_JL; end
          default: ;
        endcase
      end else begin
        case (i)
          5'd0: begin f = TONE_B4;  d = NOTE_S; end
          5'd1: begin f = TONE_B4;  d = NOTE_DH; end
          5'd2: begin f = TONE_DS5; d = NOTE_H; end
          5'd3: begin f = TONE_A4;  d = NOTE_H; end
          default: begin
            // after the intro: rest, D sharp, B flat, over and over
            if (i >= 5'd4 && i <= 5'd24) begin
              case ((32'(i) - 32'd4) % 32'd3)
                32'd0:   begin f = TONE_REST; d = NOTE_Q; end
                32'd1:   begin f = TONE_DS5;  d = NOTE_H; end
                default: begin f = TONE_AS4;  d = NOTE_H; end
              endcase
            end
          end
        endcase
      end
    endfunction

    // Smallest elapsed time at which the current note falls due
    function int unsigned due_gap();
      bit [FREQ_W-1:0] f;
      bit [LEN_W-1:0]  d;
      score_note(sel, idx, f, d);
      return (32'(d) * 32'd11 + 32'd9) / 32'd10;
    endfunction

    // Apply one accepted command and queue the tone beat it yields
    function void note_command(input logic [1:0] act, input logic [MS_W-1:0] now);
      tone_beat_t        r;
      bit [FREQ_W-1:0]   f;
      bit [LEN_W-1:0]    d;
      bit [MS_W-1:0]     elapsed;
      longint unsigned   lhs;
      longint unsigned   rhs;
      int unsigned       next;
      int unsigned       count;
      r = '0;
      case (act) inside
        ACT_ALARM, ACT_JINGLE: begin
          sel      = (act == ACT_JINGLE) ? SEL_JINGLE : SEL_ALARM;
          looping  = (act == ACT_ALARM);
          idx      = '0;
          start_ms = '0;
          playing  = 1'b1;
        end
        ACT_STOP: begin
          playing   = 1'b0;
          idx       = '0;
          r.silence = 1'b1;
        end
        ACT_TICK: begin
          if (playing) begin
            score_note(sel, idx, f, d);
            elapsed = now - start_ms;
            lhs = 64'(elapsed) * 64'd10;
            rhs = 64'(d) * 64'd11;
            if (lhs >= rhs) begin
              start_ms = now;
              if (f != TONE_REST) begin
                r.start = 1'b1;
                r.freq  = f;
                r.len   = d;
              end else begin
                r.silence = 1'b1;
              end
              // advance; wrap the alarm, end the jingle
              count = (sel == SEL_JINGLE) ? JINGLE_NOTES : ALARM_NOTES;
              next  = 32'(idx) + 32'd1;
              if (next >= count) begin
                next = 0;
                if (!looping) playing = 1'b0;
              end
              idx = next[IDX_W-1:0];
            end
          end
        end
      endcase
      r.playing = playing;
      expected_tones.push_back(r);
    endfunction

    function void compare_field(input string name, input int unsigned want,
                                input int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        mismatches++;
      end
    endfunction

    // Check one result beat against the oldest prediction
    function void check_tone(input tone_beat_t got);
      tone_beat_t want;
      if (expected_tones.size() == 0) begin
        $display("%0t: result with none expected, expected nothing, got %p", $time, got);
        mismatches++;
        return;
      end
      want = expected_tones.pop_front();
      compare_field("tone_start", want.start, got.start);
      compare_field("tone_silence", want.silence, got.silence);
      compare_field("tone_frequency_hz", want.freq, got.freq);
      compare_field("tone_length_ms", want.len, got.len);
      compare_field("is_playing", want.playing, got.playing);
    endfunction

    function int unsigned pending();
      return expected_tones.size();
    endfunction

    function int unsigned failures();
      return mismatches + expected_tones.size();
    endfunction
  endclass

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              in_valid  = 1'b0;
  logic [1:0]        action    = ACT_TICK;
  logic [MS_W-1:0]   now_ms    = '0;
  logic              out_ready = 1'b0;
  logic              in_ready;
  logic              out_valid;
  logic              tone_start;
  logic              tone_silence;
  logic [FREQ_W-1:0] tone_frequency_hz;
  logic [LEN_W-1:0]  tone_length_ms;
  logic              is_playing;

  tone_checker tones = new();
  int unsigned beats_sent   = 0;
  int unsigned send_pct     = 0;
  int unsigned sink_pct     = 0;
  int unsigned stall_left   = 0;
  int unsigned quiet_cycles = 0;

  melody_tone_sequencer uut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // Stall the receiver in random bursts
  always @(posedge clk) begin
    if (rst) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (sink_pct != 0 && $urandom_range(99) < sink_pct) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(6, 0);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Check every result beat taken
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      tones.check_tone('{tone_start, tone_silence, tone_frequency_hz, tone_length_ms,
                         is_playing});
  end

  // Bail out when no beat moves on either side for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Send one command beat, maybe after a random gap, and hold it until taken
  task automatic send_beat(input logic [1:0] act, input logic [MS_W-1:0] now);
    if (send_pct != 0 && $urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(7, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    action   <= act;
    now_ms   <= now;
    do @(posedge clk); while (!in_ready);
    if (act != ACT_TICK || tones.playing) beats_sent++;
    tones.note_command(act, now);
  endtask

  // Hold the sender until every result beat is back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (tones.pending() != 0);
  endtask

  // Tick relative to the point where the current note falls due
  task automatic tick_at(input int off);
    send_beat(ACT_TICK, MS_W'(tones.start_ms + tones.due_gap() + off));
  endtask

  // Tick near the due point most of the time, anywhere otherwise
  task automatic tick_random();
    int unsigned gap;
    int unsigned pick;
    int unsigned off;
    gap  = tones.due_gap();
    pick = $urandom_range(99);
    if (pick < 20) off = gap - 1;
    else if (pick < 45) off = gap;
    else if (pick < 75) off = gap + $urandom_range(300, 1);
    else off = $urandom_range(gap);
    if (pick >= 90) send_beat(ACT_TICK, $urandom());
    else send_beat(ACT_TICK, MS_W'(tones.start_ms + off));
  endtask

  // Play a melody through with ticks, from a random or near-wrap base
  task automatic play_melody();
    logic        jingle;
    int unsigned ticks;
    int unsigned base_pick;
    jingle = ($urandom_range(99) < 40);
    send_beat(jingle ? ACT_JINGLE : ACT_ALARM, $urandom());
    ticks     = jingle ? $urandom_range(14, 6) : $urandom_range(90, 20);
    base_pick = $urandom_range(99);
    if (base_pick < 35) send_beat(ACT_TICK, $urandom());
    else if (base_pick < 55) send_beat(ACT_TICK, 32'hFFFF_FFFF - $urandom_range(600));
    repeat (ticks) tick_random();
    if ($urandom_range(99) < 30) send_beat(ACT_STOP, $urandom());
  endtask

  // Cut a melody short with a stop or another play command
  task automatic play_broken();
    send_beat(($urandom_range(1) != 0) ? ACT_JINGLE : ACT_ALARM, $urandom());
    repeat ($urandom_range(5, 1)) tick_random();
    case ($urandom_range(2))
      0:       send_beat(ACT_STOP, $urandom());
      1:       send_beat(ACT_ALARM, $urandom());
      default: send_beat(ACT_JINGLE, $urandom());
    endcase
    repeat ($urandom_range(3)) tick_random();
  endtask

  function automatic int unsigned pick_pct();
    case ($urandom_range(2))
      0:       return 0;
      1:       return 15;
      default: return 40;
    endcase
  endfunction

  initial begin
    int unsigned pick;
    int unsigned next_drain;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // idle block: ticks do nothing, stop still silences
    send_beat(ACT_TICK, '0);
    send_beat(ACT_TICK, '1);
    send_beat(ACT_STOP, '1);
    // alarm: one short of due, then due, on through the first rest
    send_beat(ACT_ALARM, '1);
    tick_at(-1);
    tick_at(0);
    repeat (4) tick_at(0);
    send_beat(ACT_STOP, '0);
    // jingle plays once and ends on its last tone
    send_beat(ACT_JINGLE, 32'h5555_5555);
    repeat (4) tick_at(0);
    send_beat(ACT_TICK, '1);
    // elapsed time wraps past zero
    send_beat(ACT_ALARM, '0);
    send_beat(ACT_TICK, 32'hFFFF_FFF0);
    tick_at(-1);
    tick_at(0);
    // switch melody mid-play; a now_ms behind the start reads as long elapsed
    send_beat(ACT_JINGLE, '0);
    send_beat(ACT_TICK, 32'h0000_0010);
    send_beat(ACT_ALARM, 32'hAAAA_AAAA);
    send_beat(ACT_TICK, 32'h8000_0000);
    send_beat(ACT_TICK, 32'h0000_0000);
    drain();

    // random melodies, noise and broken sequences
    beats_sent = 0;
    next_drain = DRAIN_EVERY;
    while (beats_sent < TOTAL_BEATS) begin
      if (beats_sent + CALM_BEATS >= TOTAL_BEATS) begin
        send_pct = 0;
        sink_pct = 0;
      end else begin
        send_pct = pick_pct();
        sink_pct = pick_pct();
      end
      if (beats_sent >= next_drain) begin
        drain();
        next_drain += DRAIN_EVERY;
      end
      pick = $urandom_range(99);
      if (pick < 70) play_melody();
      else if (pick < 85) repeat ($urandom_range(8, 1)) send_beat(2'($urandom()), $urandom());
      else play_broken();
    end

    drain();
    repeat (10) @(posedge clk);
    if (tones.failures() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
